/* rtl/multi_channel_message_fifo_unit_defines.svh */
// Assertion macros shared by the message FIFO RTL.
`ifndef MULTI_CHANNEL_MESSAGE_FIFO_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_MESSAGE_FIFO_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MCMF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mcmf assertion failed");
// Condition in one cycle forces a consequence in the next.
`define MCMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcmf assertion failed");
`else
`define MCMF_ASSERT(label, clk, rst_n, prop)
`define MCMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/mcmf_pkg.sv */
`timescale 1ns / 1ps
package mcmf_pkg;

	localparam int CHANNELS_DEF          = 2;
	localparam int QUEUE_DEPTH_DEF       = 16;
	localparam int MAX_MESSAGE_BYTES_DEF = 1024;

	localparam int NUM_CH_W   = 2;
	localparam int MIN_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES    = 1'd1;

	localparam logic [NUM_CH_W-1:0] NUM_CH_RST    = 2'd2;
	localparam logic [MIN_W-1:0]    MIN_BYTES_RST = 11'd28;

	localparam logic [1:0] ACT_RESET = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_CHANNEL  = 3'd1;
	localparam logic [2:0] ST_QUEUE_FULL   = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH   = 3'd3;
	localparam logic [2:0] ST_EMPTY        = 3'd4;
	localparam logic [2:0] ST_READER_SMALL = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic        channel;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] reader_capacity;
	} mcmf_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  data_byte_res;
		logic [9:0]  byte_index;
		logic [10:0] msg_length;
		logic        last_of_message;
		logic        message_stored;
		logic [4:0]  free_entries;
	} mcmf_rsp_t;

endpackage

/* rtl/mcmf_ram.sv */
`timescale 1ns / 1ps
module mcmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/multi_channel_message_fifo_unit.sv */
`timescale 1ns / 1ps
`include "multi_channel_message_fifo_unit_defines.svh"
// A command is registered into valid_s1 and then into the done register, which gives the done strobe.
// A new command is taken only while busy is low, so one is in flight at a time; the message and
// length memories are read in the accept cycle and the update with write-back follows in stage 2.
// Reset: channel pointers, counters and drop flags clear, number_of_channels = 2 and
// min_message_bytes = 28; the message memories are not cleared and need no clearing pass.
// The receiver cannot stall: each result is shown on rsp for one cycle with done.
module multi_channel_message_fifo_unit
	import mcmf_pkg::*;
#(
	parameter int CHANNELS          = CHANNELS_DEF,
	parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
	parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mcmf_cmd_t             cmd,
	output logic                  done,
	output mcmf_rsp_t             rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int OFF_W   = $clog2(MAX_MESSAGE_BYTES);
	localparam int LEN_W   = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int CMP_W   = (LEN_W > MIN_W) ? LEN_W : MIN_W;
	localparam int PAY_AW  = CH_W + SLOT_W + OFF_W;
	localparam int LEN_AW  = CH_W + SLOT_W;

	// configuration
	logic [NUM_CH_W-1:0] num_ch_q;
	logic [MIN_W-1:0]    min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= NUM_CH_RST;
			min_q    <= MIN_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_CHANNELS: num_ch_q <= cfg_data[NUM_CH_W-1:0];
				CFG_MIN_BYTES:    min_q    <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// per-channel queue state
	logic [SLOT_W-1:0] rd_slot_q [CHANNELS];
	logic [SLOT_W-1:0] wr_slot_q [CHANNELS];
	logic [CNT_W-1:0]  used_q    [CHANNELS];
	logic [LEN_W-1:0]  wr_off_q  [CHANNELS];
	logic [OFF_W-1:0]  rd_off_q  [CHANNELS];
	logic              discard_q [CHANNELS];

	// stage 1: memory reads issued at accept
	logic      accept;
	logic      valid_s1;
	mcmf_cmd_t cmd_s1;
	logic [CH_W-1:0] ch_in;

	assign accept = start && !busy;
	assign busy   = valid_s1;
	assign ch_in  = CH_W'(cmd.channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	logic              pay_we;
	logic [PAY_AW-1:0] pay_waddr;
	logic [7:0]        pay_rdata;
	logic              len_we;
	logic [LEN_AW-1:0] len_waddr;
	logic [LEN_W-1:0]  len_wdata;
	logic [LEN_W-1:0]  len_rdata;

	mcmf_ram #(
		.WIDTH (8),
		.DEPTH (2 ** PAY_AW)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (cmd_s1.data_byte),
		.re    (accept),
		.raddr ({ch_in, rd_slot_q[ch_in], rd_off_q[ch_in]}),
		.rdata (pay_rdata)
	);

	mcmf_ram #(
		.WIDTH (LEN_W),
		.DEPTH (2 ** LEN_AW)
	) u_length_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (accept),
		.raddr ({ch_in, rd_slot_q[ch_in]}),
		.rdata (len_rdata)
	);

	// stage 2: read-modify-write of the addressed channel
	logic [CH_W-1:0]   ch_idx;
	logic              ch_ok;
	logic [SLOT_W-1:0] rs_cur, ws_cur;
	logic [CNT_W-1:0]  used_cur;
	logic [LEN_W-1:0]  wo_cur;
	logic [OFF_W-1:0]  ro_cur;
	logic [LEN_W-1:0]  wo_inc;
	logic [LEN_W-1:0]  ro_inc;
	logic [SLOT_W-1:0] rs_n, ws_n;
	logic [CNT_W-1:0]  used_n;
	logic [LEN_W-1:0]  wo_n;
	logic [OFF_W-1:0]  ro_n;
	logic              disc_n;
	mcmf_rsp_t         rsp_n;

	assign ch_idx   = CH_W'(cmd_s1.channel);
	assign ch_ok    = (NUM_CH_W'(cmd_s1.channel) < num_ch_q) && (int'(cmd_s1.channel) < CHANNELS);
	assign rs_cur   = rd_slot_q[ch_idx];
	assign ws_cur   = wr_slot_q[ch_idx];
	assign used_cur = used_q[ch_idx];
	assign wo_cur   = wr_off_q[ch_idx];
	assign ro_cur   = rd_off_q[ch_idx];
	assign wo_inc   = wo_cur + 1'b1;
	assign ro_inc   = LEN_W'(ro_cur) + 1'b1;

	assign pay_waddr = {ch_idx, ws_cur, wo_cur[OFF_W-1:0]};
	assign len_waddr = {ch_idx, ws_cur};
	assign len_wdata = wo_inc;

	always_comb begin
		rs_n   = rs_cur;
		ws_n   = ws_cur;
		used_n = used_cur;
		wo_n   = wo_cur;
		ro_n   = ro_cur;
		disc_n = discard_q[ch_idx];
		rsp_n  = '0;
		pay_we = 1'b0;
		len_we = 1'b0;
		if (!ch_ok) begin
			rsp_n.status = ST_BAD_CHANNEL;
		end else begin
			case (cmd_s1.action)
				ACT_RESET: begin
					rs_n   = '0;
					ws_n   = '0;
					used_n = '0;
					wo_n   = '0;
					ro_n   = '0;
					disc_n = 1'b0;
				end
				ACT_WRITE: begin
					if (discard_q[ch_idx]) begin
						// drop the rest of a refused message
						if (cmd_s1.last_byte) begin
							disc_n = 1'b0;
						end
					end else if (wo_cur == '0 && int'(used_cur) >= QUEUE_DEPTH) begin
						rsp_n.status = ST_QUEUE_FULL;
						disc_n       = !cmd_s1.last_byte;
					end else if (wo_cur >= LEN_W'(MAX_MESSAGE_BYTES)) begin
						rsp_n.status = ST_BAD_LENGTH;
						wo_n         = '0;
						disc_n       = !cmd_s1.last_byte;
					end else begin
						pay_we = 1'b1;
						if (!cmd_s1.last_byte) begin
							wo_n = wo_inc;
						end else begin
							wo_n = '0;
							if (CMP_W'(wo_inc) < CMP_W'(min_q)) begin
								rsp_n.status = ST_BAD_LENGTH;
							end else begin
								len_we = 1'b1;
								used_n = used_cur + 1'b1;
								ws_n   = (int'(ws_cur) + 1 >= QUEUE_DEPTH) ? '0 : ws_cur + 1'b1;
								rsp_n.message_stored = 1'b1;
							end
						end
					end
				end
				ACT_READ: begin
					if (used_cur == '0) begin
						rsp_n.status = ST_EMPTY;
					end else if (ro_cur == '0 && 16'(len_rdata) > cmd_s1.reader_capacity) begin
						rsp_n.status     = ST_READER_SMALL;
						rsp_n.msg_length = 11'(len_rdata);
					end else begin
						rsp_n.data_byte_res = pay_rdata;
						rsp_n.byte_index    = 10'(ro_cur);
						rsp_n.msg_length    = 11'(len_rdata);
						if (ro_inc >= len_rdata) begin
							// final byte: pop the entry
							rsp_n.last_of_message = 1'b1;
							ro_n   = '0;
							used_n = used_cur - 1'b1;
							rs_n   = (int'(rs_cur) + 1 >= QUEUE_DEPTH) ? '0 : rs_cur + 1'b1;
						end else begin
							ro_n = ro_inc[OFF_W-1:0];
						end
					end
				end
				default: ;
			endcase
			rsp_n.free_entries = 5'(CNT_W'(QUEUE_DEPTH) - used_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rd_slot_q[i] <= '0;
				wr_slot_q[i] <= '0;
				used_q[i]    <= '0;
				wr_off_q[i]  <= '0;
				rd_off_q[i]  <= '0;
				discard_q[i] <= 1'b0;
			end
		end else if (valid_s1 && ch_ok) begin
			rd_slot_q[ch_idx] <= rs_n;
			wr_slot_q[ch_idx] <= ws_n;
			used_q[ch_idx]    <= used_n;
			wr_off_q[ch_idx]  <= wo_n;
			rd_off_q[ch_idx]  <= ro_n;
			discard_q[ch_idx] <= disc_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp <= rsp_n;
		end
	end

	`MCMF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, busy, done && !busy)
	`MCMF_ASSERT(a_done_after_busy, clk, arst_n, done |-> $past(busy))
	`MCMF_ASSERT(a_stored_is_ok, clk, arst_n, (done && rsp.message_stored) |-> (rsp.status == ST_OK))
	`MCMF_ASSERT(a_bad_channel_clean, clk, arst_n, (done && rsp.status == ST_BAD_CHANNEL) |-> (rsp.free_entries == 5'd0 && !rsp.message_stored))

endmodule
